/* rtl/core/sqts_pkg.sv */
// ----------------------------------------------------------------------------
// sqts_pkg - shared constants for the single-server queue tick simulator
// Field widths of the tick and status channels, register map and reset
// values of the configuration port.
// ----------------------------------------------------------------------------
package sqts_pkg;

    // Channel field widths
    localparam int unsigned GAP_W    = 16;
    localparam int unsigned LEN_W    = 16;
    localparam int unsigned WAIT_W   = 16;
    localparam int unsigned SERVED_W = 32;
    localparam int unsigned TICK_W   = 48;
    localparam int unsigned AREA_W   = 64;

    // Configuration port
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned CFG_ADDR_W = 2;

    localparam logic [CFG_ADDR_W-1:0] ADDR_TARGET_COUNT = CFG_ADDR_W'(0);
    localparam logic [SERVED_W-1:0]   TARGET_RESET      = SERVED_W'(10000);

endpackage

/* rtl/core/sqts_tick_if.sv */
// ----------------------------------------------------------------------------
// sqts_tick_if - tick channel
// One transfer is one simulation tick with its pre-drawn gap and length.
// ----------------------------------------------------------------------------
interface sqts_tick_if;
    logic                          valid;
    logic                          ready;
    logic [sqts_pkg::GAP_W-1:0]    arrival_gap;
    logic [sqts_pkg::LEN_W-1:0]    service_len;

    modport source (output valid, output arrival_gap, output service_len, input ready);
    modport sink   (input valid, input arrival_gap, input service_len, output ready);
endinterface

/* rtl/core/sqts_stat_if.sv */
// ----------------------------------------------------------------------------
// sqts_stat_if - status channel
// One transfer carries the simulator state after one tick.
// ----------------------------------------------------------------------------
interface sqts_stat_if;
    logic                             valid;
    logic                             ready;
    logic [sqts_pkg::TICK_W-1:0]      tick_count;
    logic [sqts_pkg::SERVED_W-1:0]    served_count;
    logic [sqts_pkg::WAIT_W-1:0]      waiting_count;
    logic                             server_busy;
    logic [sqts_pkg::TICK_W-1:0]      idle_ticks;
    logic [sqts_pkg::AREA_W-1:0]      queue_area;
    logic                             run_done;
    logic                             queue_overflow;

    modport source (
        output valid, output tick_count, output served_count, output waiting_count,
        output server_busy, output idle_ticks, output queue_area, output run_done,
        output queue_overflow, input ready
    );
    modport sink (
        input valid, input tick_count, input served_count, input waiting_count,
        input server_busy, input idle_ticks, input queue_area, input run_done,
        input queue_overflow, output ready
    );
endinterface

/* rtl/core/sqts_area.sv */
// ----------------------------------------------------------------------------
// sqts_area - queue-length area accumulator
// Adds elapsed time times queue length to the running area, saturating at
// the all-ones value of the area field.
// ----------------------------------------------------------------------------
module sqts_area #(
    parameter int unsigned TIME_BITS = 48
) (
    input  logic [TIME_BITS-1:0]          i_span,
    input  logic [sqts_pkg::WAIT_W-1:0]   i_waiting,
    input  logic [sqts_pkg::AREA_W-1:0]   i_area,
    output logic [sqts_pkg::AREA_W-1:0]   o_area
);
    localparam int unsigned PROD_W = TIME_BITS + sqts_pkg::WAIT_W;
    localparam int unsigned SUM_W  =
        ((PROD_W > sqts_pkg::AREA_W) ? PROD_W : sqts_pkg::AREA_W) + 1;

    logic [PROD_W-1:0] prod;
    logic [SUM_W-1:0]  sum;

    // Form the increment and the widened sum
    assign prod = PROD_W'(i_span) * PROD_W'(i_waiting);
    assign sum  = SUM_W'(i_area) + SUM_W'(prod);

    // Clamp on any bit above the area field
    assign o_area = (|sum[SUM_W-1:sqts_pkg::AREA_W]) ? '1 : sum[sqts_pkg::AREA_W-1:0];

endmodule

/* rtl/core/single_server_queue_tick_sim.sv */
// ----------------------------------------------------------------------------
// single_server_queue_tick_sim - fixed-increment single-server queue simulator
// Each tick transfer advances the simulated clock by one until the run is done,
// handling an arrival before a departure, and returns the resulting state on o_stat.
//
//   Channel   Dir  Handshake        Payload
//   i_tick    in   valid / ready    arrival_gap, service_len
//   o_stat    out  valid / ready    tick_count .. queue_overflow
//   APB       in   psel / penable   target_count at byte address 0
//
// One tick per cycle while o_stat is not stalled: a tick is held in an input register, then one pass of
// compare/add logic plus one 48x16 multiply for the area updates the state.
// The state registers are the status output register.
// Synchronous active-low reset clears all state and sets target_count to 10000.
// A stalled status transfer holds the state; one further tick waits in the
// input register before i_tick.ready drops.
// ----------------------------------------------------------------------------
module single_server_queue_tick_sim #(
    parameter int unsigned QUEUE_MAX = 65535,
    parameter int unsigned TIME_BITS = 48
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    sqts_tick_if.sink                           i_tick,
    sqts_stat_if.source                         o_stat,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sqts_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [sqts_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [sqts_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready
);
    localparam int unsigned WW = sqts_pkg::WAIT_W;
    localparam int unsigned SW = sqts_pkg::SERVED_W;

    // Configuration
    logic [SW-1:0] r_target;

    // Input register
    logic                        r_in_valid;
    logic [sqts_pkg::GAP_W-1:0]  r_gap;
    logic [sqts_pkg::LEN_W-1:0]  r_len;

    // Simulation state, also the status register
    logic                  r_out_valid;
    logic                  r_primed,    n_primed;
    logic [TIME_BITS-1:0]  r_clock,     n_clock;
    logic [TIME_BITS-1:0]  r_next_arr,  n_next_arr;
    logic [TIME_BITS-1:0]  r_next_dep,  n_next_dep;
    logic                  r_busy,      n_busy;
    logic [WW-1:0]         r_waiting,   n_waiting;
    logic [SW-1:0]         r_served,    n_served;
    logic [TIME_BITS-1:0]  r_idle_start, n_idle_start;
    logic [TIME_BITS-1:0]  r_idle_total, n_idle_total;
    logic [sqts_pkg::AREA_W-1:0] r_area, n_area;
    logic [TIME_BITS-1:0]  r_last_chg,  n_last_chg;
    logic                  r_overflow,  n_overflow;
    logic                  r_finished,  n_finished;

    logic                  advance;
    logic [TIME_BITS-1:0]  gap_t, len_t;
    logic [TIME_BITS-1:0]  arr_eff, idle_start_eff;
    logic                  fin_start, is_arr, is_dep, area_upd;
    logic [WW-1:0]         waiting_mid;
    logic [TIME_BITS-1:0]  span;
    logic [sqts_pkg::AREA_W-1:0] area_new;

    // ------------------------------------------------------------------------
    // Configuration port
    assign pready = 1'b1;
    assign prdata = r_target;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= sqts_pkg::TARGET_RESET;
        end else if (psel && penable && pwrite && paddr == sqts_pkg::ADDR_TARGET_COUNT) begin
            r_target <= pwdata;
        end
    end

    // ------------------------------------------------------------------------
    // Handshakes: the state advances when a tick is held and the status slot
    // is free or being taken
    assign advance      = r_in_valid && (!r_out_valid || o_stat.ready);
    assign i_tick.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_tick.ready) begin
            r_in_valid <= i_tick.valid;
        end
    end

    // Hold the tick payload
    always_ff @(posedge i_clk) begin
        if (i_tick.valid && i_tick.ready) begin
            r_gap <= i_tick.arrival_gap;
            r_len <= i_tick.service_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_stat.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Tick logic
    // Draws of zero count as one tick
    assign gap_t = (r_gap == '0) ? TIME_BITS'(1) : TIME_BITS'(r_gap);
    assign len_t = (r_len == '0) ? TIME_BITS'(1) : TIME_BITS'(r_len);

    // First tick schedules the first arrival and opens the idle period
    assign arr_eff        = r_primed ? r_next_arr   : r_clock + gap_t;
    assign idle_start_eff = r_primed ? r_idle_start : r_clock;

    assign fin_start = r_finished || (r_served >= r_target);
    assign is_arr    = !fin_start && (r_clock == arr_eff);
    // A service started this tick can never end in the same tick
    assign is_dep    = !fin_start && r_busy && (r_clock == r_next_dep);

    assign waiting_mid = (is_arr && r_busy && r_waiting < WW'(QUEUE_MAX))
                         ? r_waiting + WW'(1) : r_waiting;

    // A second area update in one tick spans no time, so one pass suffices
    assign area_upd = (is_arr && r_busy) || (is_dep && waiting_mid != '0);
    assign span     = r_clock - r_last_chg;

    sqts_area #(
        .TIME_BITS (TIME_BITS)
    ) u_area (
        .i_span    (span),
        .i_waiting (r_waiting),
        .i_area    (r_area),
        .o_area    (area_new)
    );

    always_comb begin
        n_primed     = r_primed;
        n_clock      = r_clock;
        n_next_arr   = r_next_arr;
        n_next_dep   = r_next_dep;
        n_busy       = r_busy;
        n_waiting    = r_waiting;
        n_served     = r_served;
        n_idle_start = r_idle_start;
        n_idle_total = r_idle_total;
        n_area       = r_area;
        n_last_chg   = r_last_chg;
        n_overflow   = r_overflow;

        if (!fin_start) begin
            n_primed     = 1'b1;
            n_next_arr   = arr_eff;
            n_idle_start = idle_start_eff;
            n_clock      = r_clock + TIME_BITS'(1);

            // Arrival: reschedule, start service or join the queue
            if (is_arr) begin
                n_next_arr = r_clock + gap_t;
                if (!r_busy) begin
                    n_busy       = 1'b1;
                    n_next_dep   = r_clock + len_t;
                    n_idle_total = r_idle_total + (r_clock - idle_start_eff);
                end else begin
                    n_waiting = waiting_mid;
                    if (r_waiting >= WW'(QUEUE_MAX)) begin
                        n_overflow = 1'b1;
                    end
                end
            end

            // Departure: next customer or go idle
            if (is_dep) begin
                n_served = r_served + SW'(1);
                if (waiting_mid != '0) begin
                    n_waiting  = waiting_mid - WW'(1);
                    n_next_dep = r_clock + len_t;
                end else begin
                    n_busy       = 1'b0;
                    n_idle_start = r_clock;
                end
            end

            if (area_upd) begin
                n_area     = area_new;
                n_last_chg = r_clock;
            end
        end

        n_finished = fin_start || (n_served >= r_target);
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primed     <= 1'b0;
            r_clock      <= '0;
            r_next_arr   <= '0;
            r_next_dep   <= '0;
            r_busy       <= 1'b0;
            r_waiting    <= '0;
            r_served     <= '0;
            r_idle_start <= '0;
            r_idle_total <= '0;
            r_area       <= '0;
            r_last_chg   <= '0;
            r_overflow   <= 1'b0;
            r_finished   <= 1'b0;
        end else if (advance) begin
            r_primed     <= n_primed;
            r_clock      <= n_clock;
            r_next_arr   <= n_next_arr;
            r_next_dep   <= n_next_dep;
            r_busy       <= n_busy;
            r_waiting    <= n_waiting;
            r_served     <= n_served;
            r_idle_start <= n_idle_start;
            r_idle_total <= n_idle_total;
            r_area       <= n_area;
            r_last_chg   <= n_last_chg;
            r_overflow   <= n_overflow;
            r_finished   <= n_finished;
        end
    end

    // ------------------------------------------------------------------------
    // Status channel
    assign o_stat.valid          = r_out_valid;
    assign o_stat.tick_count     = sqts_pkg::TICK_W'(r_clock);
    assign o_stat.served_count   = r_served;
    assign o_stat.waiting_count  = r_waiting;
    assign o_stat.server_busy    = r_busy;
    assign o_stat.idle_ticks     = sqts_pkg::TICK_W'(r_idle_total);
    assign o_stat.queue_area     = r_area;
    assign o_stat.run_done       = r_finished;
    assign o_stat.queue_overflow = r_overflow;

endmodule
